// File: src/msr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

    localparam int CHANNELS         = 4;
    localparam int DUTY_BITS        = 10;

    localparam int CH_W             = 3;
    localparam int CH_IDX_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DUTY_W           = 10;
    localparam int REQ_W            = 16;
    localparam int CFG_W            = 10;
    localparam int CFG_IDX_W        = 2;
    localparam int SPD_W            = DUTY_BITS + 1;
    localparam int STEP_W           = CFG_W + 1;
    localparam int CMP_W            = ((REQ_W > SPD_W) ? REQ_W : SPD_W) + 2;
    localparam int ACC_W            = ((SPD_W > STEP_W) ? SPD_W : STEP_W) + 2;

    localparam int FULL_DUTY        = (1 << DUTY_BITS) - 1;
    localparam int DEFAULT_STEP     = 50;
    localparam int MIN_STEP         = 33;
    localparam int ZERO_STEP_FACTOR = 2;
    localparam int MAX_DUTY_RESET   = 1023;

    typedef logic signed [SPD_W-1:0] speed_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CH    = 2'd1,
        ST_NOT_READY = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIVER_READY = 2'd0,
        REG_SOFT_START   = 2'd1,
        REG_RAMP_STEP    = 2'd2,
        REG_MAX_DUTY     = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // result of one slew step
    typedef struct packed {
        speed_t speed;
        logic   reached;
    } step_res_t;

    function automatic logic [SPD_W-1:0] speed_mag(input speed_t spd);
        logic [SPD_W-1:0] mag;
        mag = spd[SPD_W-1] ? SPD_W'(-spd) : SPD_W'(spd);
        return mag;
    endfunction

endpackage

`default_nettype wire

// File: src/msr_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// One slew step: move cur toward target by step, clipped at target.
module msr_step_unit
    import msr_pkg::*;
(
    input  wire speed_t             cur,
    input  wire speed_t             target,
    input  wire logic [STEP_W-1:0]  step,
    output step_res_t               res
);

    logic signed [ACC_W-1:0] cur_x;
    logic signed [ACC_W-1:0] tgt_x;
    logic signed [ACC_W-1:0] stp_x;
    logic signed [ACC_W-1:0] sum;
    logic                    up;
    logic                    over;

    always_comb
    begin
        cur_x = ACC_W'(cur);
        tgt_x = ACC_W'(target);
        stp_x = signed'(ACC_W'(step));
        up    = cur_x < tgt_x;
        sum   = up ? (cur_x + stp_x) : (cur_x - stp_x);
        over  = up ? (sum > tgt_x) : (sum < tgt_x);
        res.speed   = over ? target : SPD_W'(sum);
        res.reached = over || (sum == tgt_x);
    end

endmodule

`default_nettype wire

// File: src/motor_soft_start_ramp.sv
`timescale 1ns / 1ps
`default_nettype none

// Soft-start drive command generator for CHANNELS H-bridge motor channels.
// Input channel (in_valid / in_stall): op, channel, speed_request. Set speed
// clamps the request to +/- max_duty and, with soft start on, walks the stored
// channel speed toward it one ramp step per output transaction (double step
// toward zero). Stop-all zeroes every channel, one transaction per channel.
// Output channel (out_valid / out_stall): out_channel, dir_a, dir_b, duty,
// status, last; last marks the final transaction of a command.
// Timing: a command is taken in the cycle it is offered while idle; its first
// result is registered once the output register is free, and each further
// result follows. A ramp gives up to 62 results (step floor of 33), so one
// command holds the input while its n results are made, n = number of results
// (ramp steps, CHANNELS for stop-all, 1 otherwise). The ramp distance and step
// size set n; the single shared step adder makes one step per cycle while the
// output is not stalled. in_stall is high from acceptance until the last result is loaded into the output register.
// Output stall: the sequencer holds while out_stall keeps the output register
// full; nothing is dropped. Reset: driver_ready = 0, soft start on,
// ramp_step = 50, max_duty = 1023, all channel speeds zero, output empty.
// Configuration writes are applied on the edge where cfg_wr_en is high.
module motor_soft_start_ramp
    import msr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    op,
    input  wire logic [CH_W-1:0]         channel,
    input  wire logic signed [REQ_W-1:0] speed_request,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [CH_W-1:0]              out_channel,
    output logic                         dir_a,
    output logic                         dir_b,
    output logic [DUTY_W-1:0]            duty,
    output logic [1:0]                   status,
    output logic                         last
);

    // configuration
    logic              driver_ready_reg;
    logic              soft_start_reg;
    logic [CFG_W-1:0]  ramp_step_reg;
    logic [CFG_W-1:0]  max_duty_reg;

    // sequencer and per-channel state
    state_t            state_reg, state_next;
    speed_t            chan_speed_reg [CHANNELS];
    speed_t            chan_speed_next [CHANNELS];
    logic [CH_IDX_W-1:0] cnt_reg, cnt_next;

    // command held during execution
    logic              op_reg, op_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    speed_t            target_reg, target_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [CH_W-1:0]   out_ch_reg, out_ch_next;
    logic              dir_a_reg, dir_a_next;
    logic              dir_b_reg, dir_b_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    // datapath helpers
    logic signed [CMP_W-1:0] req_x;
    logic signed [CMP_W-1:0] lim_x;
    logic signed [CMP_W-1:0] clamp_x;
    logic [CFG_W-1:0]        step_base;
    logic [STEP_W-1:0]       step_val;
    logic                    ch_ok;
    logic [CH_IDX_W-1:0]     ch_idx;
    speed_t                  cur_speed;
    step_res_t               step_res;
    logic                    out_free;
    speed_t                  emit_spd;
    logic [SPD_W-1:0]        emit_mag;

    assign ch_ok     = {1'b0, ch_reg} < (CH_W + 1)'(CHANNELS);
    assign ch_idx    = ch_reg[CH_IDX_W-1:0];
    assign cur_speed = chan_speed_reg[ch_idx];
    assign out_free  = !out_valid_reg || !out_stall;

    // step floor keeps a full-scale ramp within 62 results
    always_comb
    begin
        step_base = (ramp_step_reg < CFG_W'(MIN_STEP)) ? CFG_W'(MIN_STEP) : ramp_step_reg;
        if (target_reg == '0)
        begin
            step_val = STEP_W'(step_base * ZERO_STEP_FACTOR);
        end
        else
        begin
            step_val = STEP_W'(step_base);
        end
    end

    // request clamp, evaluated as the command is taken
    always_comb
    begin
        req_x = CMP_W'(speed_request);
        if ({{(CMP_W - CFG_W){1'b0}}, max_duty_reg} < CMP_W'(FULL_DUTY))
        begin
            lim_x = signed'({{(CMP_W - CFG_W){1'b0}}, max_duty_reg});
        end
        else
        begin
            lim_x = signed'(CMP_W'(FULL_DUTY));
        end
        if (req_x > lim_x)
        begin
            clamp_x = lim_x;
        end
        else if (req_x < -lim_x)
        begin
            clamp_x = -lim_x;
        end
        else
        begin
            clamp_x = req_x;
        end
    end

    msr_step_unit u_step (
        .cur    (cur_speed),
        .target (target_reg),
        .step   (step_val),
        .res    (step_res)
    );

    // sequencer: next state, command hold, channel writes, output load
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        ch_next         = ch_reg;
        target_next     = target_reg;
        chan_speed_next = chan_speed_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_ch_next     = out_ch_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        emit_spd        = '0;
        emit_mag        = '0;
        dir_a_next      = dir_a_reg;
        dir_b_next      = dir_b_reg;
        duty_next       = duty_reg;
        in_stall        = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    ch_next     = channel;
                    target_next = SPD_W'(clamp_x);
                    cnt_next    = '0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = ch_reg;
                    status_next    = ST_OK;
                    last_next      = 1'b1;
                    if (!driver_ready_reg)
                    begin
                        status_next = ST_NOT_READY;
                    end
                    else if (op_reg)
                    begin
                        // stop-all: one transaction per channel
                        out_ch_next = CH_W'(cnt_reg);
                        chan_speed_next[cnt_reg] = '0;
                        last_next   = (cnt_reg == CH_IDX_W'(CHANNELS - 1));
                        cnt_next    = cnt_reg + 1'b1;
                    end
                    else if (!ch_ok)
                    begin
                        status_next = ST_BAD_CH;
                    end
                    else if (!soft_start_reg)
                    begin
                        emit_spd = target_reg;
                        chan_speed_next[ch_idx] = target_reg;
                    end
                    else
                    begin
                        // at target already, the step unit returns target
                        emit_spd  = step_res.speed;
                        last_next = step_res.reached;
                        chan_speed_next[ch_idx] = step_res.speed;
                    end
                    emit_mag   = speed_mag(emit_spd);
                    dir_a_next = !emit_spd[SPD_W-1] && (emit_spd != '0);
                    dir_b_next = emit_spd[SPD_W-1];
                    duty_next  = DUTY_W'(emit_mag);
                    if (last_next)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                chan_speed_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            chan_speed_reg <= chan_speed_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            driver_ready_reg <= 1'b0;
            soft_start_reg   <= 1'b1;
            ramp_step_reg    <= CFG_W'(DEFAULT_STEP);
            max_duty_reg     <= CFG_W'(MAX_DUTY_RESET);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DRIVER_READY: driver_ready_reg <= cfg_data[0];
                REG_SOFT_START:   soft_start_reg   <= cfg_data[0];
                REG_RAMP_STEP:    ramp_step_reg    <= cfg_data;
                REG_MAX_DUTY:     max_duty_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        target_reg <= target_next;
        out_ch_reg <= out_ch_next;
        dir_a_reg  <= dir_a_next;
        dir_b_reg  <= dir_b_next;
        duty_reg   <= duty_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign dir_a       = dir_a_reg;
    assign dir_b       = dir_b_reg;
    assign duty        = duty_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// File: sim/tb_motor_soft_start_ramp.sv
`timescale 1ns / 1ps

// Self-checking bench for the soft-start drive command generator.
// Commands go in one transaction at a time; the bench keeps a shadow copy of
// the channel speeds and registers, predicts every drive update a command
// causes, and checks each output transaction in order against that list.
module tb_motor_soft_start_ramp;
    import msr_pkg::*;

    // command opcodes on the op pin
    localparam logic OP_SET      = 1'b0;
    localparam logic OP_STOP_ALL = 1'b1;

    localparam int RANDOM_CMDS = 330;
    localparam int SETTLE_CYC  = 2;        // block is idle once the last update is taken
    localparam int DRAIN_CYC   = 20;
    localparam int LIMIT_CYC   = 1_500_000;
    localparam int HOLD_AFTER  = 800;      // updates seen before the long output hold-off
    localparam int HOLD_CYC    = 400;
    localparam int MAX_PRINTS  = 40;

    // one drive update as seen on the output channel
    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic              da;
        logic              db;
        logic [DUTY_W-1:0] duty;
        logic [1:0]        st;
        logic              lst;
    } drive_res_t;

    typedef enum logic {
        ROW_CMD,
        ROW_CFG
    } row_kind_t;

    // directed table row: either a register write or a command,
    // optionally with its single drive update typed in
    typedef struct {
        row_kind_t               kind;
        cfg_reg_t                ridx;
        logic [CFG_W-1:0]        val;
        logic                    o;
        logic [CH_W-1:0]         c;
        logic signed [REQ_W-1:0] spd;
        logic                    typed;
        drive_res_t              res;
    } dir_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    op = 1'b0;
    logic [CH_W-1:0]         channel = '0;
    logic signed [REQ_W-1:0] speed_request = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [CH_W-1:0]         out_channel;
    logic                    dir_a;
    logic                    dir_b;
    logic [DUTY_W-1:0]       duty;
    logic [1:0]              status;
    logic                    last;

    // shadow of the block: registers and stored channel speeds
    logic              shadow_ready = 1'b0;
    logic              shadow_soft  = 1'b1;
    logic [CFG_W-1:0]  shadow_step  = CFG_W'(DEFAULT_STEP);
    logic [CFG_W-1:0]  shadow_max   = CFG_W'(MAX_DUTY_RESET);
    speed_t            shadow_speed [CHANNELS];

    drive_res_t        step_drives[$];      // updates of the command just taken
    drive_res_t        pending_drives[$];   // updates still owed by the block
    dir_row_t          dir_tab[$];

    int                err_cnt = 0;
    int                upd_cnt = 0;
    int                cyc = 0;
    logic              quiet_span;

    // in periodic quiet stretches the sender adds no gaps and no new random stall runs start
    assign quiet_span = (cyc % 4000) >= 3000;

    motor_soft_start_ramp DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .channel       (channel),
        .speed_request (speed_request),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_channel   (out_channel),
        .dir_a         (dir_a),
        .dir_b         (dir_b),
        .duty          (duty),
        .status        (status),
        .last          (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic drive_res_t drive_of(input logic [CH_W-1:0] c, input int spd,
                                            input status_t st, input logic lst);
        drive_res_t r;
        int         mag;
        mag    = (spd < 0) ? -spd : spd;
        r.ch   = c;
        r.da   = (spd > 0);
        r.db   = (spd < 0);
        r.duty = DUTY_W'(mag);
        r.st   = st;
        r.lst  = lst;
        return r;
    endfunction

    function automatic string fmt_drive(input drive_res_t d);
        return $sformatf("ch=%0d a=%0b b=%0b duty=%0d st=%0d last=%0b",
                         d.ch, d.da, d.db, d.duty, d.st, d.lst);
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        // keep the log readable if the block goes badly wrong
        if (err_cnt <= MAX_PRINTS)
            $display("%0t ns: ERROR %s", $time, msg);
    endtask

    // Works out the drive updates of one command and advances the shadow
    // speeds. Not-ready wins over everything, stop-all ignores the channel,
    // a bad channel only matters for set speed.
    task automatic compute_drive_updates(input logic o, input logic [CH_W-1:0] c,
                                         input logic signed [REQ_W-1:0] rq);
        int lim;
        int tgt;
        int cur;
        int stp;
        tgt = rq;
        if (!shadow_ready)
        begin
            step_drives.push_back(drive_of(c, 0, ST_NOT_READY, 1'b1));
        end
        else if (o == OP_STOP_ALL)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                shadow_speed[i] = '0;
                step_drives.push_back(drive_of(CH_W'(i), 0, ST_OK, i == CHANNELS - 1));
            end
        end
        else if (c >= CHANNELS)
        begin
            step_drives.push_back(drive_of(c, 0, ST_BAD_CH, 1'b1));
        end
        else
        begin
            lim = (shadow_max < FULL_DUTY) ? int'(shadow_max) : FULL_DUTY;
            if (tgt > lim)
                tgt = lim;
            else if (tgt < -lim)
                tgt = -lim;
            cur = shadow_speed[c];
            if (!shadow_soft || cur == tgt)
            begin
                // jump straight there, or repeat the drive already in place
                step_drives.push_back(drive_of(c, tgt, ST_OK, 1'b1));
            end
            else
            begin
                stp = (shadow_step < MIN_STEP) ? MIN_STEP : int'(shadow_step);
                if (tgt == 0)
                    stp = stp * ZERO_STEP_FACTOR;
                // slew toward the target, clipping the final step
                while (cur != tgt)
                begin
                    if (cur < tgt)
                        cur = (cur + stp > tgt) ? tgt : cur + stp;
                    else
                        cur = (cur - stp < tgt) ? tgt : cur - stp;
                    step_drives.push_back(drive_of(c, cur, ST_OK, cur == tgt));
                end
            end
            shadow_speed[c] = speed_t'(tgt);
        end
    endtask

    // sender gap: mostly back to back, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_span || r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Offers one command, holds it until the block takes it, then records
    // the updates it owes: typed ones for checked table rows, else predicted.
    task automatic send_cmd(input logic o, input logic [CH_W-1:0] c,
                            input logic signed [REQ_W-1:0] s,
                            input logic typed, input drive_res_t res);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        channel       <= c;
        speed_request <= s;
        do
            @(posedge clk);
        while (in_stall);
        compute_drive_updates(o, c, s);
        if (typed)
            pending_drives.push_back(res);
        else
            foreach (step_drives[i])
                pending_drives.push_back(step_drives[i]);
        step_drives.delete();
    endtask

    // Register writes only land while the block is idle.
    task automatic write_reg(input cfg_reg_t ridx, input logic [CFG_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= ridx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (ridx)
            REG_DRIVER_READY: shadow_ready = val[0];
            REG_SOFT_START:   shadow_soft  = val[0];
            REG_RAMP_STEP:    shadow_step  = val;
            REG_MAX_DUTY:     shadow_max   = val;
            default:          ;
        endcase
    endtask

    function automatic logic [CFG_W-1:0] pick_cfg_val(input cfg_reg_t ridx);
        logic [CFG_W-1:0] v;
        v = CFG_W'($urandom_range(0, 1023));
        case (ridx)
            // flags only look at bit 0; upper bits are random noise
            REG_DRIVER_READY: v[0] = ($urandom_range(0, 99) < 90);
            REG_SOFT_START:   v[0] = ($urandom_range(0, 99) < 80);
            REG_RAMP_STEP:
                case ($urandom_range(0, 7))
                    0:       v = '0;
                    1:       v = CFG_W'(MIN_STEP - 1);
                    2:       v = CFG_W'(MIN_STEP);
                    3:       v = '1;
                    4:       v = CFG_W'($urandom_range(0, MIN_STEP - 1));
                    5, 6:    v = CFG_W'($urandom_range(MIN_STEP, 150));
                    default: ;
                endcase
            REG_MAX_DUTY:
                case ($urandom_range(0, 7))
                    0:       v = '0;
                    1:       v = CFG_W'(1);
                    2:       v = '1;
                    3:       ;
                    default: v = CFG_W'($urandom_range(200, 1023));
                endcase
            default: ;
        endcase
        return v;
    endfunction

    function automatic dir_row_t cfg_row(input cfg_reg_t ridx, input logic [CFG_W-1:0] v);
        dir_row_t r;
        r       = '{kind: ROW_CFG, ridx: ridx, val: v, o: OP_SET, c: '0, spd: '0,
                    typed: 1'b0, res: '0};
        return r;
    endfunction

    function automatic dir_row_t cmd_row(input logic o, input logic [CH_W-1:0] c,
                                         input logic signed [REQ_W-1:0] s);
        dir_row_t r;
        r       = '{kind: ROW_CMD, ridx: REG_DRIVER_READY, val: '0, o: o, c: c, spd: s,
                    typed: 1'b0, res: '0};
        return r;
    endfunction

    function automatic dir_row_t chk_row(input logic o, input logic [CH_W-1:0] c,
                                         input logic signed [REQ_W-1:0] s,
                                         input drive_res_t res);
        dir_row_t r;
        r       = cmd_row(o, c, s);
        r.typed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    // cycle count and run limit
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYC)
        begin
            $display("** motor_soft_start_ramp: FAILED **");
            $finish;
        end
    end

    // Output side stall pattern. Short random stalls, quiet stretches, and
    // one long hold-off while the sender keeps offering commands.
    initial
    begin : out_stall_gen
        int   run_left;
        int   hold_left;
        logic run_lvl;
        logic held_off;
        run_left  = 0;
        hold_left = 0;
        run_lvl   = 1'b0;
        held_off  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && upd_cnt >= HOLD_AFTER)
            begin
                held_off  = 1'b1;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
                out_stall <= run_lvl;
            end
            else
            begin
                if (quiet_span)
                begin
                    run_lvl  = 1'b0;
                    run_left = 0;
                end
                else if ($urandom_range(0, 99) < 35)
                begin
                    run_lvl  = 1'b1;
                    run_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                            : $urandom_range(7, 11);
                end
                else
                begin
                    run_lvl  = 1'b0;
                    run_left = $urandom_range(0, 5);
                end
                out_stall <= run_lvl;
            end
        end
    end

    // Output checker: every taken transaction must match the oldest owed update.
    always @(posedge clk)
    begin : drive_mon
        drive_res_t got;
        drive_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.ch   = out_channel;
            got.da   = dir_a;
            got.db   = dir_b;
            got.duty = duty;
            got.st   = status;
            got.lst  = last;
            upd_cnt++;
            if (pending_drives.size() == 0)
            begin
                report_mismatch({"unexpected drive update ", fmt_drive(got)});
            end
            else
            begin
                want = pending_drives.pop_front();
                if (got !== want)
                    report_mismatch({"drive update got ", fmt_drive(got),
                                     " exp ", fmt_drive(want)});
            end
        end
    end

    initial
    begin : stim
        logic                    o;
        logic [CH_W-1:0]         c;
        logic signed [REQ_W-1:0] s;
        cfg_reg_t                wr_idx;
        int                      phase_cmds;
        int                      rnd_sent;
        foreach (shadow_speed[i])
            shadow_speed[i] = '0;

        // Directed part. After reset the driver is not ready, so the first
        // commands answer not-ready, stop-all included.
        dir_tab.push_back(chk_row(OP_SET, 0, 16'sd100, drive_of(0, 0, ST_NOT_READY, 1'b1)));
        dir_tab.push_back(chk_row(OP_STOP_ALL, 5, 16'sd0,
                                  drive_of(5, 0, ST_NOT_READY, 1'b1)));
        dir_tab.push_back(cfg_row(REG_DRIVER_READY, 10'd1));
        dir_tab.push_back(cmd_row(OP_SET, 0, 16'sd32767));      // full forward ramp
        dir_tab.push_back(chk_row(OP_SET, 0, 16'sd32767,        // already at target
                                  drive_of(0, FULL_DUTY, ST_OK, 1'b1)));
        dir_tab.push_back(cmd_row(OP_SET, 0, -16'sd32768));     // forward to reverse
        dir_tab.push_back(chk_row(OP_SET, 4, 16'sd100, drive_of(4, 0, ST_BAD_CH, 1'b1)));
        dir_tab.push_back(chk_row(OP_SET, 7, -16'sd1, drive_of(7, 0, ST_BAD_CH, 1'b1)));
        dir_tab.push_back(cmd_row(OP_SET, 1, -16'sd5));
        dir_tab.push_back(cmd_row(OP_SET, 1, 16'sd0));          // double step toward zero
        dir_tab.push_back(cmd_row(OP_STOP_ALL, 3, 16'sh2AAA));
        dir_tab.push_back(cfg_row(REG_RAMP_STEP, 10'd0));       // floored step
        dir_tab.push_back(cmd_row(OP_SET, 2, 16'sd1023));
        dir_tab.push_back(cmd_row(OP_SET, 2, -16'sd1023));      // longest ramp
        dir_tab.push_back(cfg_row(REG_RAMP_STEP, 10'd1023));
        dir_tab.push_back(cmd_row(OP_SET, 3, -16'sd32768));
        dir_tab.push_back(cmd_row(OP_SET, 3, 16'sd0));
        dir_tab.push_back(cfg_row(REG_MAX_DUTY, 10'd0));        // every request clamps to 0
        dir_tab.push_back(cmd_row(OP_SET, 2, 16'sd32767));
        dir_tab.push_back(chk_row(OP_SET, 1, -16'sd32768, drive_of(1, 0, ST_OK, 1'b1)));
        dir_tab.push_back(cfg_row(REG_MAX_DUTY, 10'd1023));
        dir_tab.push_back(cfg_row(REG_SOFT_START, 10'd0));      // direct jumps
        dir_tab.push_back(chk_row(OP_SET, 2, 16'sd32767, drive_of(2, FULL_DUTY, ST_OK, 1'b1)));
        dir_tab.push_back(chk_row(OP_SET, 3, -16'sd32768,
                                  drive_of(3, -FULL_DUTY, ST_OK, 1'b1)));
        dir_tab.push_back(chk_row(OP_SET, 3, 16'sd0, drive_of(3, 0, ST_OK, 1'b1)));
        dir_tab.push_back(cfg_row(REG_SOFT_START, 10'd1));
        dir_tab.push_back(cfg_row(REG_RAMP_STEP, 10'd33));
        dir_tab.push_back(cfg_row(REG_MAX_DUTY, 10'd500));
        dir_tab.push_back(cmd_row(OP_SET, 1, 16'sh5555));
        dir_tab.push_back(cmd_row(OP_SET, 2, -16'sd700));
        dir_tab.push_back(cmd_row(OP_STOP_ALL, 6, -16'sd1));
        dir_tab.push_back(cfg_row(REG_DRIVER_READY, 10'd0));
        dir_tab.push_back(chk_row(OP_SET, 2, -16'sd1, drive_of(2, 0, ST_NOT_READY, 1'b1)));
        dir_tab.push_back(cfg_row(REG_DRIVER_READY, 10'd1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_reg(dir_tab[i].ridx, dir_tab[i].val);
            else
                send_cmd(dir_tab[i].o, dir_tab[i].c, dir_tab[i].spd,
                         dir_tab[i].typed, dir_tab[i].res);
        end

        // Random part in phases: reprogram while idle, then a burst of commands.
        rnd_sent = 0;
        while (rnd_sent < RANDOM_CMDS)
        begin
            write_reg(REG_DRIVER_READY, pick_cfg_val(REG_DRIVER_READY));
            repeat ($urandom_range(0, 3))
            begin
                wr_idx = cfg_reg_t'($urandom_range(0, 3));
                write_reg(wr_idx, pick_cfg_val(wr_idx));
            end
            phase_cmds = shadow_ready ? $urandom_range(15, 40) : $urandom_range(3, 6);
            repeat (phase_cmds)
            begin
                o = ($urandom_range(0, 99) < 8) ? OP_STOP_ALL : OP_SET;
                c = ($urandom_range(0, 99) < 85) ? CH_W'($urandom_range(0, CHANNELS - 1))
                                                 : CH_W'($urandom_range(CHANNELS, 7));
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5:
                        s = REQ_W'($urandom);
                    14, 15:
                        s = '0;
                    16, 17:
                        // ask for the speed the channel already holds
                        s = (c < CHANNELS) ? REQ_W'(shadow_speed[c]) : '0;
                    18:
                        s = 16'sd32767;
                    19:
                        s = -16'sd32768;
                    default:
                        s = REQ_W'(int'($urandom_range(0, 2200)) - 1100);
                endcase
                send_cmd(o, c, s, 1'b0, '0);
                rnd_sent++;
            end
        end

        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (err_cnt == 0)
            $display("** motor_soft_start_ramp: PASSED **");
        else
            $display("** motor_soft_start_ramp: FAILED **");
        $finish;
    end

endmodule
